>>> hdl/mrst_pkg.sv
// ----------------------------------------------------------------------------
// mrst_pkg
// Shared types and constants for the multicast ring slot tracker.
// ----------------------------------------------------------------------------
package mrst_pkg;

  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned MAX_READERS_DEF = 64;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd4096;

  typedef enum logic [2:0] {
    OP_OPEN   = 3'd0,
    OP_CLOSE  = 3'd1,
    OP_WRITE  = 3'd2,
    OP_START  = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFREE  = 3'd1,
    ST_BADLEN  = 3'd2,
    ST_BUSY    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_OFFLINE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SWEEP,
    S_FINAL,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic exec;      // decode, issue reads of slot stores
    logic read;      // evaluate read data
    logic sweep;     // clear drop bits in one slot
    logic final_wr;  // commit result
    logic out_take;  // output transaction done
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
  } stat_t;

endpackage

>>> hdl/multicast_ring_slot_tracker.sv
// ----------------------------------------------------------------------------
// multicast_ring_slot_tracker
// Slot ownership tracking for a multicast message ring.
// ----------------------------------------------------------------------------
// One command transaction in on s_axis (op, reader, length, expired), one
// result transaction out on m_axis (status, reader_id, slot, slot_length,
// slot_freed). One command is handled at a time: s_axis_tready is high only
// while the block is idle.
// Close and evicting writes add a sweep that clears the dropped reader bits
// from the slot reader memory, one slot per cycle.
// The result is held on m_axis until taken; a stalled receiver holds off the
// next command.
// cfg_valid/cfg_ready write max_length; write only while idle.
// Reset (rst, synchronous) empties the reader mask, slots and write index and
// sets max_length to 4096.
// ----------------------------------------------------------------------------
module multicast_ring_slot_tracker import mrst_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned MAX_READERS = MAX_READERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // op[2:0], reader[8:3], length[24:9], expired[25]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], reader_id[8:3], slot[12:9], slot_length[28:13], slot_freed[29]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t        cmd;
  stat_t       stat;
  logic [2:0]  status;
  logic [5:0]  reader_id;
  logic [3:0]  slot;
  logic [15:0] slot_length;
  logic        slot_freed;

  assign cfg_ready = 1'b1;

  mrst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd)
  );

  mrst_dp #(
    .SLOTS       (SLOTS),
    .MAX_READERS (MAX_READERS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (s_axis_tdata[2:0]),
    .reader      (s_axis_tdata[8:3]),
    .length      (s_axis_tdata[24:9]),
    .expired     (s_axis_tdata[25]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .stat        (stat),
    .status      (status),
    .reader_id   (reader_id),
    .slot        (slot),
    .slot_length (slot_length),
    .slot_freed  (slot_freed)
  );

  assign m_axis_tdata = {2'b00, slot_freed, slot_length, slot, reader_id, status};

endmodule

>>> hdl/mrst_ctrl.sv
// ----------------------------------------------------------------------------
// mrst_ctrl
// Sequencer: load, read slot stores, optional sweep over all slots, commit.
// ----------------------------------------------------------------------------
module mrst_ctrl import mrst_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output logic  in_ready,
  output logic  out_valid,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  state_next = S_READ;
      S_READ:  state_next = stat.need_sweep ? S_SWEEP : S_FINAL;
      S_SWEEP: if (stat.sweep_last) state_next = S_FINAL;
      S_FINAL: state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    out_valid    = (state == S_OUT);
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.read     = (state == S_READ);
    cmd.sweep    = (state == S_SWEEP);
    cmd.final_wr = (state == S_FINAL);
    cmd.out_take = (state == S_OUT) && out_ready;
  end

endmodule

>>> hdl/mrst_dp.sv
// ----------------------------------------------------------------------------
// mrst_dp
// Datapath: reader mask, slot reader/length memories, per-reader read index.
// ----------------------------------------------------------------------------
module mrst_dp import mrst_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned MAX_READERS = MAX_READERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [2:0]  op,
  input  logic [5:0]  reader,
  input  logic [15:0] length,
  input  logic        expired,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  output stat_t       stat,
  output logic [2:0]  status,
  output logic [5:0]  reader_id,
  output logic [3:0]  slot,
  output logic [15:0] slot_length,
  output logic        slot_freed
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [63:0] VALID_MASK = (MAX_READERS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << MAX_READERS) - 64'd1);

  logic [15:0]   max_length;
  logic [63:0]   reader_mask;
  logic [SW-1:0] write_index;
  logic [63:0]   online;
  logic [63:0]   srd_mem [SLOTS];
  logic [15:0]   len_mem [SLOTS];
  logic [SW-1:0] ridx_mem [64];

  logic [2:0]    op_q;
  logic [5:0]    reader_q;
  logic [15:0]   length_q;
  logic          expired_q;
  logic [SW-1:0] ridx_q;
  logic [63:0]   srd_q;
  logic [15:0]   len_q;
  logic [63:0]   drop;
  logic [SW-1:0] sweep_idx;
  logic          wr_go;
  logic [SW-1:0] s_addr;
  logic          wr_ok;

  logic [63:0] rbit, freebits;
  logic        in_range;
  logic [5:0]  first_free;

  logic [2:0]    status_next;
  logic [5:0]    reader_id_next;
  logic [3:0]    slot_next;
  logic [15:0]   slot_length_next;
  logic          slot_freed_next;
  logic [63:0]   reader_mask_next;
  logic [63:0]   online_next;
  logic [SW-1:0] write_index_next;

  assign rbit     = 64'd1 << reader_q;
  assign in_range = |(VALID_MASK & rbit);
  assign freebits = ~reader_mask & VALID_MASK;

  always_comb begin
    first_free = '0;
    for (int i = 63; i >= 0; i--) begin
      if (freebits[i]) first_free = 6'(i);
    end
  end

  // read address for slot memories
  always_comb begin
    if (op_q == OP_WRITE) s_addr = write_index;
    else                  s_addr = ridx_q;
  end

  assign wr_ok = (op_q == OP_WRITE) && (length_q != 16'd0) && (length_q <= max_length)
                 && ((srd_mem[s_addr] == 64'd0) || expired_q);

  assign stat.need_sweep = (|drop) || (wr_ok && (|srd_mem[s_addr]));
  assign stat.sweep_last = (sweep_idx == SW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op;
      reader_q  <= reader;
      length_q  <= length;
      expired_q <= expired;
    end
    if (cmd.exec) begin
      ridx_q <= ridx_mem[reader_q];
    end
    if (cmd.read) begin
      srd_q <= srd_mem[s_addr];
      len_q <= len_mem[s_addr];
    end
    if (cmd.final_wr && wr_go) begin
      len_mem[write_index] <= length_q;
    end
    if (cmd.final_wr && op_q == OP_FINISH && in_range && online[reader_q]) begin
      ridx_mem[reader_q] <= SW'((SLOTS == (1 << SW)) ? ridx_q + 1'b1 :
                            ((ridx_q == SW'(SLOTS - 1)) ? '0 : ridx_q + 1'b1));
    end
    if (cmd.final_wr && op_q == OP_OPEN && |freebits) begin
      ridx_mem[first_free] <= write_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) srd_mem[i] <= '0;
    end else begin
      if (cmd.sweep) begin
        srd_mem[sweep_idx] <= srd_mem[sweep_idx] & ~drop;
      end
      if (cmd.final_wr && wr_go) begin
        srd_mem[write_index] <= reader_mask & ~drop;
      end
      if (cmd.final_wr && op_q == OP_FINISH && in_range && online[reader_q]) begin
        srd_mem[ridx_q] <= srd_q & ~rbit;
      end
    end
  end

  always_comb begin
    status_next      = ST_OK;
    reader_id_next   = '0;
    slot_next        = '0;
    slot_length_next = '0;
    slot_freed_next  = 1'b0;
    reader_mask_next = reader_mask;
    online_next      = online;
    write_index_next = write_index;
    unique case (op_q) inside
      OP_OPEN: begin
        if (|freebits) begin
          reader_mask_next = reader_mask | (64'd1 << first_free);
          online_next      = online | (64'd1 << first_free);
          reader_id_next   = first_free;
        end else begin
          status_next = ST_NOFREE;
        end
      end
      OP_CLOSE: begin
        reader_mask_next = reader_mask & ~drop;
        online_next      = online & ~drop;
      end
      OP_WRITE: begin
        if (length_q == 0 || length_q > max_length) begin
          status_next = ST_BADLEN;
        end else begin
          slot_next = 4'(write_index);
          if (!wr_go) begin
            status_next = ST_BUSY;
          end else begin
            reader_mask_next = reader_mask & ~drop;
            online_next      = online & ~drop;
            write_index_next = (write_index == SW'(SLOTS - 1)) ? '0
                               : write_index + 1'b1;
          end
        end
      end
      OP_START, OP_FINISH: begin
        if (!in_range || !online[reader_q]) begin
          status_next = ST_OFFLINE;
        end else begin
          slot_next = 4'(ridx_q);
          if (op_q == OP_START) begin
            if (|(srd_q & rbit)) slot_length_next = len_q;
            else                 status_next = ST_EMPTY;
          end else begin
            slot_freed_next = ((srd_q & ~rbit) == 64'd0);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length  <= MAX_LEN_RESET;
      reader_mask <= '0;
      write_index <= '0;
      online      <= '0;
      sweep_idx   <= '0;
      wr_go       <= 1'b0;
      drop        <= '0;
      status      <= ST_OK;
      reader_id   <= '0;
      slot        <= '0;
      slot_length <= '0;
      slot_freed  <= 1'b0;
    end else begin
      if (cfg_valid) max_length <= cfg_data;
      if (cmd.exec) begin
        sweep_idx <= '0;
        wr_go     <= 1'b0;
        drop      <= (op_q == OP_CLOSE && in_range) ? rbit : '0;
      end
      if (cmd.read && wr_ok) begin
        wr_go <= 1'b1;
        drop  <= srd_mem[s_addr];
      end
      if (cmd.sweep) sweep_idx <= sweep_idx + 1'b1;
      if (cmd.final_wr) begin
        status      <= status_next;
        reader_id   <= reader_id_next;
        slot        <= slot_next;
        slot_length <= slot_length_next;
        slot_freed  <= slot_freed_next;
        reader_mask <= reader_mask_next;
        online      <= online_next;
        write_index <= write_index_next;
      end
    end
  end

endmodule
